[rtl/rpn_pkg.sv]
// Shared types and constants for the RPN stack calculator.
`default_nettype none
package rpn_pkg;
    localparam int StackDepth = 128;
    localparam int FracBits = 16;
    localparam int AddrW = $clog2(StackDepth);
    localparam int CntW = $clog2(StackDepth + 1);
    localparam int DepthW = 8;
    localparam int QueueDepth = 2;
    localparam int DivW = 32 + FracBits;

    typedef enum logic [3:0] {
        OP_PUSH = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3,
        OP_DIV = 4'd4, OP_MOD = 4'd5, OP_POP_SHOW = 4'd6, OP_SWAP = 4'd7,
        OP_PEEK = 4'd8, OP_CLEAR = 4'd9, OP_DUP = 4'd10, OP_UNKNOWN = 4'd11
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [30:0] value;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  operation;
        logic [30:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] shown_value;
        logic               shown_valid;
        logic [1:0]         underflow_count;
        logic               stack_full_error;
        logic               zero_divisor_error;
        logic               unknown_command_error;
        logic [7:0]         depth;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_B, ST_WAIT_B, ST_RD_A, ST_WAIT_A, ST_MUL, ST_DIV,
        ST_FIX, ST_PUSH1, ST_PUSH2, ST_DONE
    } t_state;
endpackage
`default_nettype wire

[rtl/rpn_stream_if.sv]
// Valid/ready channel interface.
`default_nettype none
interface rpn_stream_if #(parameter int Width = 1);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/rpn_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module rpn_ram #(
    parameter int Width = 32,
    parameter int Depth = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_addr,
    input  wire logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]              o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[rtl/rpn_front.sv]
// Front end: classifies tokens and queues them for the executor.
`default_nettype none
module rpn_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire rpn_pkg::t_in   i_in,
    output logic                o_cmd_valid,
    input  wire logic           i_cmd_ready,
    output rpn_pkg::t_cmd       o_cmd
);
    import rpn_pkg::*;
    t_cmd r_q [QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd w_cls;
    logic w_push, w_pop;

    always_comb begin
        w_cls.value = i_in.value;
        if (i_in.operation > 4'(OP_DUP)) begin
            w_cls.op = OP_UNKNOWN;
        end else begin
            w_cls.op = t_op'(i_in.operation);
        end
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cls;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue overfilled");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !w_pop) |=> r_cnt == 2'd2) else $error("queue lost entry");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !o_cmd_valid) else $error("empty queue valid");
endmodule
`default_nettype wire

[rtl/rpn_exec.sv]
// Back end: stack memory, arithmetic sequencer and serial divider.
`default_nettype none
module rpn_exec (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_ready,
    input  wire rpn_pkg::t_cmd  i_cmd,
    output logic                o_res_valid,
    input  wire logic           i_res_ready,
    output rpn_pkg::t_out       o_res
);
    import rpn_pkg::*;

    t_state r_state, n_state;
    t_cmd r_cmd;
    logic [CntW-1:0] r_cnt;
    logic signed [31:0] r_a, r_b, r_res, r_shown;
    logic r_valid, r_zdiv, r_full, r_push_res;
    logic [1:0] r_uf;
    logic [63:0] r_prod;
    logic [DivW-1:0] r_quo;
    logic [32:0] r_rem;
    logic [5:0] r_step;
    logic r_out_valid;
    t_out r_out;

    logic w_we;
    logic [AddrW-1:0] w_addr;
    logic [31:0] w_wdata, w_rdata;
    logic w_has;
    logic [31:0] w_ma, w_mb;
    logic [33:0] w_remsh;
    logic [32:0] w_diff;
    logic [DivW-1:0] w_dvd;
    logic [DivW-1:0] w_src;

    rpn_ram #(.Width(32), .Depth(StackDepth)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    assign w_has = (r_cnt != '0);
    assign w_ma = r_a[31] ? 32'(-r_a) : r_a;
    assign w_mb = r_b[31] ? 32'(-r_b) : r_b;
    assign w_dvd = (r_cmd.op == OP_MOD) ? {FracBits'(0), w_ma} : {w_ma, FracBits'(0)};
    assign w_src = (r_step == 6'(DivW)) ? w_dvd : r_quo;
    assign w_remsh = {r_rem, w_src[DivW-1]};
    assign w_diff = 33'(w_remsh - {2'b0, w_mb});

    function automatic logic signed [31:0] f_sat(input logic [63:0] m, input logic neg);
        logic signed [31:0] v;
        if (neg) begin
            v = (m >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-m);
        end else begin
            v = (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : m[31:0];
        end
        return v;
    endfunction

    function automatic logic signed [31:0] f_sum(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic sub);
        logic signed [32:0] s;
        s = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
        if (s > 33'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (s < -33'sh0_8000_0000) return 32'sh8000_0000;
        return s[31:0];
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_cmd_valid && !r_out_valid) n_state = ST_RD_B;
            ST_RD_B: n_state = ST_WAIT_B;
            ST_WAIT_B: n_state = ST_RD_A;
            ST_RD_A: n_state = ST_WAIT_A;
            ST_WAIT_A: begin
                if (r_cmd.op == OP_MUL) begin
                    n_state = ST_MUL;
                end else if ((r_cmd.op == OP_DIV || r_cmd.op == OP_MOD) && r_b != 0) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_FIX;
                end
            end
            ST_MUL: n_state = ST_FIX;
            ST_DIV: if (r_step == 6'd1) n_state = ST_FIX;
            ST_FIX: n_state = ST_PUSH1;
            ST_PUSH1: n_state = ST_PUSH2;
            ST_PUSH2: n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // memory port: write on push states, read top otherwise
    always_comb begin
        w_we = 1'b0;
        w_wdata = r_res;
        w_addr = AddrW'(r_cnt - 1'b1);
        case (r_state)
            ST_PUSH1: begin
                w_we = r_push_res && (r_cnt < CntW'(StackDepth));
                w_addr = AddrW'(r_cnt);
                w_wdata = (r_cmd.op == OP_SWAP) ? r_b : r_res;
            end
            ST_PUSH2: begin
                w_we = (r_cmd.op == OP_SWAP || r_cmd.op == OP_DUP)
                    && (r_cnt < CntW'(StackDepth));
                w_addr = AddrW'(r_cnt);
                w_wdata = (r_cmd.op == OP_SWAP) ? r_a : r_b;
            end
            default: ;
        endcase
    end

    assign o_cmd_ready = (r_state == ST_DONE);
    assign o_res_valid = r_out_valid;
    assign o_res = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_cmd <= i_cmd;
                    r_uf <= 2'd0; r_full <= 1'b0; r_zdiv <= 1'b0;
                    r_valid <= 1'b0; r_shown <= '0; r_a <= '0; r_b <= '0;
                    r_push_res <= 1'b0; r_res <= '0;
                end
                ST_RD_B: ;
                ST_WAIT_B: begin
                    // first pop (b), inspection for peek, or depth reset for clear
                    case (r_cmd.op)
                        OP_PEEK: begin
                            r_valid <= w_has; r_shown <= w_has ? w_rdata : '0;
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POP_SHOW,
                        OP_SWAP, OP_DUP: begin
                            if (w_has) begin
                                r_b <= w_rdata; r_cnt <= r_cnt - 1'b1;
                            end else begin
                                r_b <= '0; r_uf <= r_uf + 2'd1;
                            end
                        end
                        OP_CLEAR: r_cnt <= '0;
                        default: ;
                    endcase
                end
                ST_RD_A: ;
                ST_WAIT_A: begin
                    if ((r_cmd.op == OP_ADD || r_cmd.op == OP_SUB || r_cmd.op == OP_MUL
                         || r_cmd.op == OP_SWAP
                         || ((r_cmd.op == OP_DIV || r_cmd.op == OP_MOD) && r_b != 0))) begin
                        if (w_has) begin
                            r_a <= w_rdata; r_cnt <= r_cnt - 1'b1;
                        end else begin
                            r_a <= '0; r_uf <= r_uf + 2'd1;
                        end
                    end
                    r_rem <= '0; r_step <= 6'(DivW);
                end
                ST_MUL: r_prod <= 64'(w_ma) * 64'(w_mb);
                ST_DIV: begin
                    if (!w_diff[32]) r_rem <= w_diff;
                    else r_rem <= w_remsh[32:0];
                    r_quo <= {w_src[DivW-2:0], !w_diff[32]};
                    r_step <= r_step - 6'd1;
                end
                ST_FIX: begin
                    case (r_cmd.op)
                        OP_PUSH: begin r_res <= {1'b0, r_cmd.value}; r_push_res <= 1'b1; end
                        OP_ADD, OP_SUB: begin
                            r_res <= f_sum(r_a, r_b, r_cmd.op == OP_SUB);
                            r_push_res <= 1'b1;
                        end
                        OP_MUL: begin
                            r_res <= f_sat(r_prod >> FracBits, r_a[31] ^ r_b[31]);
                            r_push_res <= 1'b1;
                        end
                        OP_DIV: begin
                            if (r_b == 0) r_zdiv <= 1'b1;
                            else begin
                                r_res <= f_sat(64'(r_quo), r_a[31] ^ r_b[31]);
                                r_push_res <= 1'b1;
                            end
                        end
                        OP_MOD: begin
                            if (r_b == 0) r_zdiv <= 1'b1;
                            else begin
                                r_res <= f_sat(64'(r_rem[31:0]), r_a[31]);
                                r_push_res <= 1'b1;
                            end
                        end
                        OP_POP_SHOW: begin r_valid <= 1'b1; r_shown <= r_b; end
                        OP_SWAP: begin r_res <= r_a; r_push_res <= 1'b1; end
                        OP_DUP: begin r_push_res <= 1'b1; r_res <= r_b; end
                        default: ;
                    endcase
                end
                ST_PUSH1: if (w_we) r_cnt <= r_cnt + 1'b1;
                          else if (r_push_res) r_full <= 1'b1;
                ST_PUSH2: begin
                    if (r_cmd.op == OP_SWAP || r_cmd.op == OP_DUP) begin
                        if (w_we) r_cnt <= r_cnt + 1'b1;
                        else r_full <= 1'b1;
                    end
                end
                default: ;
            endcase
            r_state <= n_state;
            if (r_state == ST_DONE) begin
                r_out.shown_value <= r_shown;
                r_out.shown_valid <= r_valid;
                r_out.underflow_count <= r_uf;
                r_out.stack_full_error <= r_full;
                r_out.zero_divisor_error <= r_zdiv;
                r_out.unknown_command_error <= (r_cmd.op == OP_UNKNOWN);
                r_out.depth <= DepthW'(r_cnt);
            end
            if (r_state == ST_DONE) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(StackDepth)) else $error("stack depth overflow");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_cmd_ready || r_state == ST_DONE)
        else $error("ready outside done");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_res_ready) |=> r_out_valid) else $error("result dropped");
endmodule
`default_nettype wire

[rtl/rpn_stack_calculator_core.sv]
// Top level of the RPN stack calculator.
// Channels: in_ch carries {operation, value} tokens; out_ch carries one result
// per token (shown value, flags, depth). Both are valid/ready interfaces.
// A two-entry token queue sits in front of the executor, so tokens are taken
// while a command runs. Div and mod use the one-bit-per-cycle divider
// over 48 dividend bits. The executor finishes each token before it
// takes the next.
// The stack lives in a single-port RAM, one read or
// write per cycle. Reset empties the stack (depth 0) and the queue; stack
// contents are not cleared. When the receiver stalls the result stays in the
// output register and the executor waits before starting the next token;
// the queue keeps accepting until it holds two tokens.
`default_nettype none
module rpn_stack_calculator_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rpn_stream_if.sink   in_ch,
    rpn_stream_if.source out_ch
);
    import rpn_pkg::*;
    logic w_cmd_valid, w_cmd_ready;
    t_cmd w_cmd;
    t_in w_in;
    t_out w_out;

    assign w_in = t_in'(in_ch.data);
    assign out_ch.data = w_out;

    rpn_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready), .i_in(w_in),
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    rpn_exec u_exec (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .o_res_valid(out_ch.valid), .i_res_ready(out_ch.ready), .o_res(w_out)
    );
endmodule
`default_nettype wire

[tb/rpn_result_checker.sv]
// Checker for the RPN stack calculator: predicts each result and compares it with the output.
module rpn_result_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic [34:0]        i_in_data,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic [45:0]        i_out_data,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import rpn_pkg::*;

    logic signed [31:0] calc_stack[StackDepth];
    int unsigned        calc_depth;
    int unsigned        pop_misses;
    bit                 push_dropped;
    t_out               expected_results[$];

    function automatic logic signed [31:0] pop_entry();
        if (calc_depth > 0) begin
            calc_depth--;
            return calc_stack[calc_depth];
        end
        pop_misses++;
        return 32'sd0;
    endfunction

    function automatic void push_entry(logic signed [31:0] v);
        if (calc_depth < StackDepth) begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end else begin
            push_dropped = 1'b1;
        end
    endfunction

    function automatic logic signed [31:0] clamp_sum(longint x);
        if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic longint unsigned abs_of(logic signed [31:0] a);
        longint sa;
        sa = a;
        return (sa < 0) ? longint'(-sa) : sa;
    endfunction

    function automatic logic signed [31:0] signed_from(longint unsigned m, bit neg);
        longint sm;
        if (neg) begin
            if (m >= 64'h8000_0000) return 32'sh80000000;
            sm = m;
            sm = -sm;
            return sm[31:0];
        end
        if (m > 64'h7FFF_FFFF) return 32'sh7FFFFFFF;
        return m[31:0];
    endfunction

    function automatic t_out calc_result(t_in tok);
        t_out               r;
        logic signed [31:0] a;
        logic signed [31:0] b;
        r = '0;
        pop_misses = 0;
        push_dropped = 1'b0;
        case (tok.operation)
            OP_PUSH: push_entry({1'b0, tok.value});
            OP_ADD: begin
                b = pop_entry();
                a = pop_entry();
                push_entry(clamp_sum(longint'(a) + longint'(b)));
            end
            OP_SUB: begin
                b = pop_entry();
                a = pop_entry();
                push_entry(clamp_sum(longint'(a) - longint'(b)));
            end
            OP_MUL: begin
                b = pop_entry();
                a = pop_entry();
                push_entry(signed_from((abs_of(a) * abs_of(b)) >> FracBits,
                                       (a < 0) != (b < 0)));
            end
            OP_DIV: begin
                b = pop_entry();
                if (b == 0) begin
                    r.zero_divisor_error = 1'b1;
                end else begin
                    a = pop_entry();
                    push_entry(signed_from((abs_of(a) << FracBits) / abs_of(b),
                                           (a < 0) != (b < 0)));
                end
            end
            OP_MOD: begin
                b = pop_entry();
                if (b == 0) begin
                    r.zero_divisor_error = 1'b1;
                end else begin
                    a = pop_entry();
                    push_entry(signed_from(abs_of(a) % abs_of(b), a < 0));
                end
            end
            OP_POP_SHOW: begin
                r.shown_value = pop_entry();
                r.shown_valid = 1'b1;
            end
            OP_SWAP: begin
                a = pop_entry();
                b = pop_entry();
                push_entry(a);
                push_entry(b);
            end
            OP_PEEK: begin
                if (calc_depth > 0) begin
                    r.shown_value = calc_stack[calc_depth - 1];
                    r.shown_valid = 1'b1;
                end
            end
            OP_CLEAR: calc_depth = 0;
            OP_DUP: begin
                a = pop_entry();
                push_entry(a);
                push_entry(a);
            end
            default: r.unknown_command_error = 1'b1;
        endcase
        r.underflow_count = pop_misses[1:0];
        r.stack_full_error = push_dropped;
        r.depth = calc_depth[7:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out got;
        t_out want;
        if (!i_rst_n) begin
            expected_results.delete();
            calc_depth = 0;
            o_fail_count <= 0;
            o_result_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                o_result_count <= o_result_count + 1;
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%t unexpected result %p", $realtime, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("%t mismatch: expected %p, got %p",
                                     $realtime, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(calc_result(t_in'(i_in_data)));
            o_pending <= expected_results.size();
        end
    end
endmodule

[tb/tb_rpn_stack_calculator_core.sv]
// Testbench top for the RPN stack calculator: reset, token stimulus, flow control and verdict.
module tb_rpn_stack_calculator_core;
    import rpn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 1_000_000;
    localparam logic [30:0] MaxVal = 31'h7FFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    int   cycles = 0;
    int   send_idle_pct;
    int   stall_pct;
    int   tokens_sent;
    int   fail_count;
    int   pending;
    int   result_count;

    rpn_stream_if #(.Width($bits(t_in)))  in_ch();
    rpn_stream_if #(.Width($bits(t_out))) out_ch();

    rpn_stack_calculator_core DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    rpn_result_checker checker_inst (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid),
        .i_in_ready(in_ch.ready),
        .i_in_data(in_ch.data),
        .i_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_out_data(out_ch.data),
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_result_count(result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_token(logic [3:0] op, logic [30:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {op, val};
        do @(posedge i_clk); while (!in_ch.ready);
        tokens_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [30:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 31'($urandom_range(0, 20)) << FracBits;
            1: return 31'($urandom_range(0, 65535));
            2: return MaxVal;
            3: return 31'd0;
            default: return 31'($urandom());
        endcase
    endfunction

    function automatic logic [3:0] rand_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 38) return OP_PUSH;
        if (pick < 48) return OP_ADD;
        if (pick < 58) return OP_SUB;
        if (pick < 66) return OP_MUL;
        if (pick < 73) return OP_DIV;
        if (pick < 79) return OP_MOD;
        if (pick < 84) return OP_POP_SHOW;
        if (pick < 88) return OP_SWAP;
        if (pick < 92) return OP_PEEK;
        if (pick < 94) return OP_CLEAR;
        if (pick < 98) return OP_DUP;
        return 4'($urandom_range(OP_UNKNOWN, 15));
    endfunction

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic run_phase(int idle, int stall, int count);
        int n;
        send_idle_pct = idle;
        stall_pct = stall;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 59) == 0) begin
                // fill to overflow, then exercise a full stack
                repeat (StackDepth + 3) send_token(OP_PUSH, rand_value());
                send_token(OP_DUP, '0);
                send_token(OP_SWAP, '0);
                send_token(OP_PEEK, '0);
                n += StackDepth + 6;
            end else begin
                send_token(rand_op(), rand_value());
                n++;
            end
        end
    endtask

    initial begin
        tokens_sent = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_token(OP_POP_SHOW, '0);
        send_token(OP_PEEK, '0);
        send_token(OP_SWAP, '0);
        send_token(OP_DUP, '0);
        send_token(OP_CLEAR, '0);
        send_token(OP_ADD, '0);
        send_token(OP_DIV, '0);
        send_token(OP_PUSH, MaxVal);
        send_token(OP_PUSH, MaxVal);
        send_token(OP_ADD, '0);
        send_token(OP_PUSH, '0);
        send_token(OP_PUSH, MaxVal);
        send_token(OP_SUB, '0);
        send_token(OP_PUSH, MaxVal);
        send_token(OP_SUB, '0);
        send_token(OP_PEEK, '0);
        send_token(OP_PUSH, MaxVal);
        send_token(OP_MUL, '0);
        send_token(OP_PUSH, 31'h0002_8000);
        send_token(OP_DIV, '0);
        send_token(OP_PUSH, '0);
        send_token(OP_MOD, '0);
        send_token(OP_PUSH, 31'h0003_0000);
        send_token(OP_MOD, '0);
        send_token(4'(OP_UNKNOWN), '0);
        send_token(4'd15, MaxVal);
        send_token(OP_POP_SHOW, '0);

        run_phase(0, 0, 425);
        run_phase(69, 0, 425);
        drain();
        repeat (50) @(negedge i_clk);
        run_phase(0, 69, 425);
        run_phase(20, 20, 425);
        drain();
        stall_pct = 0;
        repeat (100) @(negedge i_clk);

        $display("Sent %0d tokens over four flow-control phases, checked %0d results.",
                 tokens_sent, result_count);
        $display("Covered all commands, empty and full stack, zero divisors, saturation.");
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
